// ----- design/pntf_pkg.sv -----
// ----------------------------------------------------------------------------
// pntf_pkg: shared types and codes for the Petri net transition engine.
// Holds the command and status codes and the input and result item types.
// ----------------------------------------------------------------------------
package pntf_pkg;

  // Table sizes follow the widths of the index fields below.
  localparam int NUM_PLACES      = 64;
  localparam int NUM_TRANSITIONS = 32;

  typedef enum logic [2:0] {
    CMD_DEF_PLACE = 3'd0,
    CMD_DEF_TRANS = 3'd1,
    CMD_CONS_ARC  = 3'd2,
    CMD_PROD_ARC  = 3'd3,
    CMD_FIRE      = 3'd4,
    CMD_READ      = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_EN   = 3'd1,
    ST_NOT_WILL = 3'd2,
    ST_FULL     = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_NEG_WT   = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [5:0]         place_index;
    logic [4:0]         transition_index;
    logic signed [15:0] amount;
    logic               willing;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               fired;
    logic signed [15:0] place_tokens;
    logic               place_defined;
  } out_item_t;

  localparam logic signed [15:0] TOK_MAX = 16'sh7FFF;
  localparam logic signed [15:0] TOK_MIN = 16'sh8000;

endpackage

// ----- design/pntf_tok_mem.sv -----
// ----------------------------------------------------------------------------
// pntf_tok_mem: token count memory.
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pntf_tok_mem #(
  parameter int NP = 64,
  parameter int AW = 6
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [15:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic signed [15:0] rdata
);

  logic signed [15:0] mem [NP];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- design/pntf_arc_mem.sv -----
// ----------------------------------------------------------------------------
// pntf_arc_mem: arc list memory, one row of arc slots per transition.
// Each entry holds a place index and a weight; read data registered.
// ----------------------------------------------------------------------------
module pntf_arc_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int W     = 21
) (
  input  logic         clk,
  input  logic         we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- design/petri_net_transition_firing.sv -----
// ----------------------------------------------------------------------------
// petri_net_transition_firing: Petri net token game engine.
// Accepts one command item at a time and answers each with one result item.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result appears
// on the out_ ports for one cycle, marked by out_valid, and cannot be held
// off. Define and arc commands pass through S_RD0 and S_DONE, a read also
// through S_RD1 for its token memory read. A fire walks the consumer arcs
// once to check them and, if it fires, once more to subtract, then the
// producer arcs to add. A checked arc takes an arc memory read and a token
// memory read; a subtracted or added arc also takes a token write-back.
// Token counts and arcs live in synchronous memories; valid bits and arc
// counts are flip-flops cleared by reset.
module petri_net_transition_firing #(
  parameter int MAX_ARCS        = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pntf_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output pntf_pkg::out_item_t  out_item
);

  localparam int PW  = $clog2(pntf_pkg::NUM_PLACES);
  localparam int TW  = $clog2(pntf_pkg::NUM_TRANSITIONS);
  localparam int SW  = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
  localparam int CW  = $clog2(MAX_ARCS + 1);
  localparam int AD  = pntf_pkg::NUM_TRANSITIONS << SW;
  localparam int AAW = TW + SW;
  localparam int ARW = PW + 16;

  typedef enum logic [3:0] {
    S_IDLE, S_ARD, S_ARC, S_TRD, S_TCHK, S_TWR, S_RD0, S_RD1, S_DONE
  } state_t;

  // Phases of a fire: check consumers, subtract consumers, add producers.
  typedef enum logic [1:0] {PH_CHK, PH_SUB, PH_ADD} phase_t;

  state_t                 state_r;
  phase_t                 phase_r;
  pntf_pkg::in_item_t     cmd_r;
  logic [SW-1:0]          idx_r;
  logic [pntf_pkg::NUM_PLACES-1:0]      pvalid_r;
  logic [pntf_pkg::NUM_TRANSITIONS-1:0] tvalid_r;
  logic [CW-1:0]          ccnt_r [pntf_pkg::NUM_TRANSITIONS];
  logic [CW-1:0]          pcnt_r [pntf_pkg::NUM_TRANSITIONS];
  logic [PW-1:0]          arc_p_r;
  logic signed [15:0]     arc_w_r;
  pntf_pkg::out_item_t    res_r;
  logic                   ov_r;

  logic                   tok_we;
  logic [PW-1:0]          tok_waddr, tok_raddr;
  logic signed [15:0]     tok_wdata, tok_rdata;
  logic                   c_we, p_we;
  logic [AAW-1:0]         a_waddr, a_raddr;
  logic [ARW-1:0]         a_wdata, c_rdata, p_rdata;

  logic [TW-1:0] t_i;
  logic [PW-1:0] p_i;
  logic          p_ok, t_ok;
  logic [CW-1:0] cur_cnt;
  logic signed [16:0] sum;
  logic signed [15:0] sat;

  assign t_i  = cmd_r.transition_index[TW-1:0];
  assign p_i  = cmd_r.place_index[PW-1:0];
  assign p_ok = 32'(cmd_r.place_index) < pntf_pkg::NUM_PLACES;
  assign t_ok = 32'(cmd_r.transition_index) < pntf_pkg::NUM_TRANSITIONS;
  assign cur_cnt = (phase_r == PH_ADD) ? pcnt_r[t_i] : ccnt_r[t_i];

  always_comb begin
    if (phase_r == PH_ADD) sum = 17'(tok_rdata) + 17'(arc_w_r);
    else                   sum = 17'(tok_rdata) - 17'(arc_w_r);
    if (sum > 17'sd32767)       sat = pntf_pkg::TOK_MAX;
    else if (sum < -17'sd32768) sat = pntf_pkg::TOK_MIN;
    else                        sat = sum[15:0];
  end

  // Arc memory ports.
  assign a_raddr = {t_i, idx_r};
  assign a_waddr = (cmd_r.command == pntf_pkg::CMD_CONS_ARC)
                 ? {t_i, ccnt_r[t_i][SW-1:0]} : {t_i, pcnt_r[t_i][SW-1:0]};
  assign a_wdata = {p_i, cmd_r.amount};

  // The arc's place stays on the read port through the check cycle so that
  // the write-back cycle sees its token count.
  assign tok_raddr = (state_r == S_TRD || state_r == S_TCHK) ? arc_p_r : p_i;
  assign tok_waddr = (state_r == S_TWR) ? arc_p_r : p_i;
  assign tok_wdata = (state_r == S_TWR) ? sat : cmd_r.amount;

  always_comb begin
    tok_we = 1'b0;
    c_we   = 1'b0;
    p_we   = 1'b0;
    if (state_r == S_TWR) tok_we = 1'b1;
    if (state_r == S_RD0 && cmd_r.command == pntf_pkg::CMD_DEF_PLACE && p_ok)
      tok_we = 1'b1;
    if (state_r == S_RD0 && t_ok && tvalid_r[t_i] && p_ok && !cmd_r.amount[15]) begin
      if (cmd_r.command == pntf_pkg::CMD_CONS_ARC && 32'(ccnt_r[t_i]) < MAX_ARCS)
        c_we = 1'b1;
      if (cmd_r.command == pntf_pkg::CMD_PROD_ARC && 32'(pcnt_r[t_i]) < MAX_ARCS)
        p_we = 1'b1;
    end
  end

  pntf_tok_mem #(.NP(pntf_pkg::NUM_PLACES), .AW(PW)) u_tok (
    .clk(clk), .we(tok_we), .waddr(tok_waddr), .wdata(tok_wdata),
    .raddr(tok_raddr), .rdata(tok_rdata)
  );

  pntf_arc_mem #(.DEPTH(AD), .AW(AAW), .W(ARW)) u_cons (
    .clk(clk), .we(c_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(c_rdata)
  );

  pntf_arc_mem #(.DEPTH(AD), .AW(AAW), .W(ARW)) u_prod (
    .clk(clk), .we(p_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(p_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_CHK;
      pvalid_r <= '0;
      tvalid_r <= '0;
      ov_r     <= 1'b0;
      idx_r    <= '0;
      for (int i = 0; i < pntf_pkg::NUM_TRANSITIONS; i++) begin
        ccnt_r[i] <= '0;
        pcnt_r[i] <= '0;
      end
    end else begin
      ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= in_item;
            res_r   <= '0;
            idx_r   <= '0;
            phase_r <= PH_CHK;
            state_r <= S_RD0;
          end
        end
        S_RD0: begin
          state_r <= S_DONE;
          case (cmd_r.command)
            pntf_pkg::CMD_DEF_PLACE: begin
              if (!p_ok) res_r.status <= pntf_pkg::ST_UNKNOWN;
              else pvalid_r[p_i] <= 1'b1;
            end
            pntf_pkg::CMD_DEF_TRANS: begin
              if (!t_ok) res_r.status <= pntf_pkg::ST_UNKNOWN;
              else begin
                tvalid_r[t_i] <= 1'b1;
                ccnt_r[t_i]   <= '0;
                pcnt_r[t_i]   <= '0;
              end
            end
            pntf_pkg::CMD_CONS_ARC, pntf_pkg::CMD_PROD_ARC: begin
              if (!t_ok || !tvalid_r[t_i] || !p_ok)
                res_r.status <= pntf_pkg::ST_UNKNOWN;
              else if (cmd_r.amount[15]) res_r.status <= pntf_pkg::ST_NEG_WT;
              else if (c_we) ccnt_r[t_i] <= ccnt_r[t_i] + 1'b1;
              else if (p_we) pcnt_r[t_i] <= pcnt_r[t_i] + 1'b1;
              else res_r.status <= pntf_pkg::ST_FULL;
            end
            pntf_pkg::CMD_FIRE: begin
              if (!t_ok || !tvalid_r[t_i]) res_r.status <= pntf_pkg::ST_UNKNOWN;
              else if (ccnt_r[t_i] == '0) begin
                if (!cmd_r.willing) res_r.status <= pntf_pkg::ST_NOT_WILL;
                else begin
                  res_r.fired <= 1'b1;
                  phase_r     <= PH_ADD;
                  state_r     <= (pcnt_r[t_i] == '0) ? S_DONE : S_ARD;
                end
              end else state_r <= S_ARD;
            end
            pntf_pkg::CMD_READ: begin
              if (!p_ok || !pvalid_r[p_i]) res_r.status <= pntf_pkg::ST_UNKNOWN;
              else state_r <= S_RD1;
            end
            default: res_r.status <= pntf_pkg::ST_UNKNOWN;
          endcase
        end
        S_RD1: begin
          res_r.place_tokens  <= tok_rdata;
          res_r.place_defined <= 1'b1;
          state_r <= S_DONE;
        end
        S_ARD: state_r <= S_ARC;  // arc memory read in flight
        S_ARC: begin
          if (phase_r == PH_ADD) begin
            arc_p_r <= p_rdata[ARW-1:16];
            arc_w_r <= p_rdata[15:0];
          end else begin
            arc_p_r <= c_rdata[ARW-1:16];
            arc_w_r <= c_rdata[15:0];
          end
          state_r <= S_TRD;
        end
        S_TRD: state_r <= S_TCHK;  // token memory read in flight
        S_TCHK: begin
          if (phase_r == PH_CHK) begin
            if (!pvalid_r[arc_p_r] || tok_rdata < arc_w_r) begin
              res_r.status <= pntf_pkg::ST_NOT_EN;
              state_r <= S_DONE;
            end else if (32'(idx_r) + 1 < 32'(cur_cnt)) begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_ARD;
            end else if (!cmd_r.willing) begin
              res_r.status <= pntf_pkg::ST_NOT_WILL;
              state_r <= S_DONE;
            end else begin
              res_r.fired <= 1'b1;
              idx_r   <= '0;
              phase_r <= PH_SUB;
              state_r <= S_ARD;
            end
          end else if (phase_r == PH_ADD && !pvalid_r[arc_p_r]) begin
            // Producer arc to an undefined place is skipped.
            if (32'(idx_r) + 1 < 32'(cur_cnt)) begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_ARD;
            end else state_r <= S_DONE;
          end else state_r <= S_TWR;
        end
        S_TWR: begin
          if (32'(idx_r) + 1 < 32'(cur_cnt)) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_ARD;
          end else if (phase_r == PH_SUB && pcnt_r[t_i] != '0) begin
            idx_r   <= '0;
            phase_r <= PH_ADD;
            state_r <= S_ARD;
          end else state_r <= S_DONE;
        end
        S_DONE: begin
          ov_r    <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.fired |-> out_item.status == pntf_pkg::ST_OK)
    else $error("fired with nonzero status");
  a_def_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.place_defined |-> out_item.status == pntf_pkg::ST_OK)
    else $error("read result with bad status");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result repeated");
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

endmodule
